// ===== rtl/pls_pkg.sv =====
`timescale 1ns / 1ps
package pls_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int VALUE_BITS_DEF = 32;

  localparam int ACTION_BITS = 3;
  localparam int POS_BITS    = 5;
  localparam int DATA_BITS   = 32;
  localparam int COUNT_BITS  = 5;
  localparam int STATUS_BITS = 2;

  typedef logic [DATA_BITS-1:0]  data_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_APPEND = 3'd0,
    ACT_INSERT = 3'd1,
    ACT_DELETE = 3'd2,
    ACT_READ   = 3'd3,
    ACT_DUMP   = 3'd4
  } action_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_DUMP = 1'b1
  } fsm_e;

  typedef struct packed {
    logic [ACTION_BITS-1:0] action;
    logic [POS_BITS-1:0]    position;
    data_t                  value;
  } request_t;

  typedef struct packed {
    data_t                  read_value;
    count_t                 element_count;
    logic [STATUS_BITS-1:0] status;
    logic                   last;
  } result_t;

  // per-cell load selects, at most one set in a cycle
  typedef struct packed {
    logic load_left;
    logic load_new;
    logic load_right;
  } cell_ctrl_t;

endpackage

// ===== rtl/positional_list_store.sv =====
`timescale 1ns / 1ps
// A result is registered and appears in the cycle after its request is taken.
// Append, insert, delete and read each give one result and leave the store idle; a dump of n
// elements streams n results back to back; busy is high, and no request is taken, before the final one.
// Insert and delete shift the cells from the given position onward, all in parallel.
// Reset (rst, synchronous) empties the store; the receiver cannot stall results.
module positional_list_store #(
  parameter int CAPACITY   = pls_pkg::CAPACITY_DEF,
  parameter int VALUE_BITS = pls_pkg::VALUE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  pls_pkg::request_t request,
  output pls_pkg::result_t  result,
  output logic              strobe
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int XW = (CW > pls_pkg::POS_BITS) ? CW : pls_pkg::POS_BITS;

  pls_pkg::fsm_e state, state_next;
  logic [CW-1:0] count, count_next;
  logic [IW-1:0] idx, idx_next;
  logic          strobe_next;
  pls_pkg::result_t result_next;

  logic [VALUE_BITS-1:0] cell_data [CAPACITY];
  pls_pkg::cell_ctrl_t   cell_ctrl [CAPACITY];
  logic [VALUE_BITS-1:0] new_data;
  logic [VALUE_BITS-1:0] rd_data;
  logic [IW-1:0]         sel;

  logic [XW-1:0] pos_x, cnt_x, ins_pos;
  logic          accept, ins_en, del_en, full, empty;
  pls_pkg::action_e act;

  assign accept   = start && (state == pls_pkg::FSM_IDLE);
  assign busy     = (state == pls_pkg::FSM_DUMP);
  assign act      = pls_pkg::action_e'(request.action);
  assign pos_x    = XW'(request.position);
  assign cnt_x    = XW'(count);
  assign full     = (cnt_x == XW'(CAPACITY));
  assign empty    = (count == '0);
  assign new_data = VALUE_BITS'(request.value);

  // shared read port: dump index while streaming, 0 for a dump request, else request position
  always_comb begin
    if (state == pls_pkg::FSM_DUMP) begin
      sel = idx;
    end else if (act == pls_pkg::ACT_DUMP) begin
      sel = '0;
    end else begin
      sel = IW'(pos_x);
    end
  end
  assign rd_data = cell_data[sel];

  always_comb begin
    state_next  = state;
    count_next  = count;
    idx_next    = idx;
    strobe_next = 1'b0;
    ins_en      = 1'b0;
    del_en      = 1'b0;
    ins_pos     = pos_x;
    result_next = '0;
    case (state)
      pls_pkg::FSM_IDLE: begin
        if (accept) begin
          strobe_next      = 1'b1;
          result_next.last = 1'b1;
          result_next.status = pls_pkg::ST_OK;
          case (act)
            pls_pkg::ACT_APPEND: begin
              if (full) begin
                result_next.status = pls_pkg::ST_FULL;
              end else begin
                ins_en  = 1'b1;
                ins_pos = cnt_x;
              end
            end
            pls_pkg::ACT_INSERT: begin
              if (full) begin
                result_next.status = pls_pkg::ST_FULL;
              end else if (pos_x > cnt_x) begin
                result_next.status = pls_pkg::ST_RANGE;
              end else begin
                ins_en = 1'b1;
              end
            end
            pls_pkg::ACT_DELETE: begin
              if (empty) begin
                result_next.status = pls_pkg::ST_EMPTY;
              end else if (pos_x >= cnt_x) begin
                result_next.status = pls_pkg::ST_RANGE;
              end else begin
                del_en = 1'b1;
              end
            end
            pls_pkg::ACT_READ: begin
              if (empty) begin
                result_next.status = pls_pkg::ST_EMPTY;
              end else if (pos_x >= cnt_x) begin
                result_next.status = pls_pkg::ST_RANGE;
              end else begin
                result_next.read_value = pls_pkg::data_t'(rd_data);
              end
            end
            pls_pkg::ACT_DUMP: begin
              if (empty) begin
                result_next.status = pls_pkg::ST_EMPTY;
              end else begin
                result_next.read_value = pls_pkg::data_t'(rd_data);
                if (count != CW'(1)) begin
                  result_next.last = 1'b0;
                  state_next       = pls_pkg::FSM_DUMP;
                  idx_next         = IW'(1);
                end
              end
            end
            default: begin
            end
          endcase
          if (ins_en) begin
            count_next = count + CW'(1);
          end else if (del_en) begin
            count_next = count - CW'(1);
          end
        end
      end
      pls_pkg::FSM_DUMP: begin
        strobe_next            = 1'b1;
        result_next.status     = pls_pkg::ST_OK;
        result_next.read_value = pls_pkg::data_t'(rd_data);
        result_next.last       = ((XW'(idx) + XW'(1)) == cnt_x);
        if (result_next.last) begin
          state_next = pls_pkg::FSM_IDLE;
        end else begin
          idx_next = idx + IW'(1);
        end
      end
      default: begin
        state_next = pls_pkg::FSM_IDLE;
      end
    endcase
    result_next.element_count = pls_pkg::count_t'(count_next);
  end

  // per-cell selects: the insert point takes the new value, cells past it take the left neighbor,
  // cells from the delete point take the right neighbor
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_ctrl[i].load_left  = ins_en && (XW'(i) > ins_pos);
      cell_ctrl[i].load_new   = ins_en && (XW'(i) == ins_pos);
      cell_ctrl[i].load_right = del_en && (XW'(i) >= pos_x);
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VALUE_BITS-1:0] left_in, right_in;
    if (g == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_final
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = cell_data[g+1];
    end
    pls_cell #(
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[g]),
      .left_data  (left_in),
      .right_data (right_in),
      .new_data   (new_data),
      .data       (cell_data[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= pls_pkg::FSM_IDLE;
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    idx    <= idx_next;
    result <= result_next;
  end

endmodule

// ===== rtl/pls_cell.sv =====
`timescale 1ns / 1ps
module pls_cell #(
  parameter int VALUE_BITS = pls_pkg::VALUE_BITS_DEF
) (
  input  logic                   clk,
  input  pls_pkg::cell_ctrl_t    ctrl,
  input  logic [VALUE_BITS-1:0]  left_data,
  input  logic [VALUE_BITS-1:0]  right_data,
  input  logic [VALUE_BITS-1:0]  new_data,
  output logic [VALUE_BITS-1:0]  data
);

  always_ff @(posedge clk) begin
    if (ctrl.load_left) begin
      data <= left_data;
    end else if (ctrl.load_new) begin
      data <= new_data;
    end else if (ctrl.load_right) begin
      data <= right_data;
    end
  end

endmodule

// ===== rtl/pls_check.sv =====
`timescale 1ns / 1ps
module pls_check (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input pls_pkg::result_t  result,
  input logic              strobe
);

  // every request taken answers on the next cycle
  a_request_answered: assert property (@(posedge clk) disable iff (rst)
    (!rst && start && !busy) |=> strobe)
    else $error("request taken without a result on the next cycle");

  // a dump stream has no gaps until its final element
  a_stream_unbroken: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.last) |=> strobe)
    else $error("dump stream broke before its final element");

  // while busy a non-final dump result is on the ports
  a_busy_streams: assert property (@(posedge clk) disable iff (rst)
    busy |-> (strobe && !result.last))
    else $error("busy without a streaming dump result");

  // rejected requests give a single zero-valued result
  a_reject_single: assert property (@(posedge clk) disable iff (rst)
    (strobe && (result.status != pls_pkg::ST_OK)) |-> (result.last && result.read_value == '0))
    else $error("rejected request gave a value or more than one result");

endmodule

bind positional_list_store pls_check u_pls_check (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .result  (result),
  .strobe  (strobe)
);

// ===== tb/tb_positional_list_store.sv =====
`timescale 1ns / 1ps
module tb_positional_list_store;
  import pls_pkg::*;

  localparam int CAPACITY     = CAPACITY_DEF;
  localparam int POS_MAX      = (1 << POS_BITS) - 1;
  localparam int ACT_CODE_MAX = (1 << ACTION_BITS) - 1;
  localparam int RANDOM_ITEMS = 330;
  localparam int PHASE_LEN    = 83;

  typedef struct packed {
    request_t   req;
    logic       drain;
    logic [6:0] idle_pct;
  } stim_item_t;

  typedef struct packed {
    result_t     res;
    logic [31:0] born;
  } want_entry_t;

  logic     clk;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  request_t request = '0;
  result_t  result;
  logic     strobe;

  stim_item_t  pending[$];
  want_entry_t want_results[$];
  stim_item_t  sent_item;
  want_entry_t head_want;

  data_t       mirror_cells [CAPACITY];
  int          mirror_count = 0;
  int          gen_count = 0;
  int          mismatches = 0;
  logic [31:0] cycle_no = '0;

  positional_list_store dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .result  (result),
    .strobe  (strobe)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("positional_list_store verification failed");
    $finish;
  end

  function automatic void push_expect(data_t v, status_e st, logic fin, logic [31:0] stamp);
    want_entry_t w;
    w.res.read_value    = v;
    w.res.element_count = count_t'(mirror_count);
    w.res.status        = st;
    w.res.last          = fin;
    w.born              = stamp;
    want_results.push_back(w);
  endfunction

  function automatic void predict_list_action(request_t rq, logic [31:0] stamp);
    int p;
    int i;
    p = rq.position;
    case (rq.action)
      ACT_APPEND: begin
        if (mirror_count >= CAPACITY) begin
          push_expect('0, ST_FULL, 1'b1, stamp);
        end else begin
          mirror_cells[mirror_count] = rq.value;
          mirror_count++;
          push_expect('0, ST_OK, 1'b1, stamp);
        end
      end
      ACT_INSERT: begin
        if (mirror_count >= CAPACITY) begin
          push_expect('0, ST_FULL, 1'b1, stamp);
        end else if (p > mirror_count) begin
          push_expect('0, ST_RANGE, 1'b1, stamp);
        end else begin
          for (i = mirror_count; i > p; i--) mirror_cells[i] = mirror_cells[i-1];
          mirror_cells[p] = rq.value;
          mirror_count++;
          push_expect('0, ST_OK, 1'b1, stamp);
        end
      end
      ACT_DELETE: begin
        if (mirror_count == 0) begin
          push_expect('0, ST_EMPTY, 1'b1, stamp);
        end else if (p >= mirror_count) begin
          push_expect('0, ST_RANGE, 1'b1, stamp);
        end else begin
          for (i = p; i + 1 < mirror_count; i++) mirror_cells[i] = mirror_cells[i+1];
          mirror_count--;
          push_expect('0, ST_OK, 1'b1, stamp);
        end
      end
      ACT_READ: begin
        if (mirror_count == 0) begin
          push_expect('0, ST_EMPTY, 1'b1, stamp);
        end else if (p >= mirror_count) begin
          push_expect('0, ST_RANGE, 1'b1, stamp);
        end else begin
          push_expect(mirror_cells[p], ST_OK, 1'b1, stamp);
        end
      end
      ACT_DUMP: begin
        if (mirror_count == 0) begin
          push_expect('0, ST_EMPTY, 1'b1, stamp);
        end else begin
          for (i = 0; i < mirror_count; i++)
            push_expect(mirror_cells[i], ST_OK, i + 1 == mirror_count, stamp);
        end
      end
      default: begin
        push_expect('0, ST_OK, 1'b1, stamp);
      end
    endcase
  endfunction

  function automatic void flag_mismatch(string msg);
    if (mismatches < 10) $display("%s", msg);
    mismatches++;
  endfunction

  // track occupancy at generation time so positions mostly land in range
  task automatic queue_request(input logic [ACTION_BITS-1:0] act, input int pos,
                               input data_t val, input bit drain, input int idle);
    stim_item_t it;
    it.req.action   = act;
    it.req.position = pos[POS_BITS-1:0];
    it.req.value    = val;
    it.drain        = drain;
    it.idle_pct     = idle[6:0];
    pending.push_back(it);
    case (act)
      ACT_APPEND: if (gen_count < CAPACITY) gen_count++;
      ACT_INSERT: if (gen_count < CAPACITY && pos <= gen_count) gen_count++;
      ACT_DELETE: if (gen_count > 0 && pos < gen_count) gen_count--;
      default: ;
    endcase
  endtask

  function automatic data_t pick_value();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom();
  endfunction

  // driver: hold a request while busy, otherwise offer the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        sent_item = pending.pop_front();
        predict_list_action(sent_item.req, cycle_no);
      end
      if (!(start && busy)) begin
        if (pending.size() > 0 && !(pending[0].drain && want_results.size() != 0) &&
            $urandom_range(99) >= pending[0].idle_pct) begin
          start   <= 1'b1;
          request <= pending[0].req;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: results predicted at this very edge cannot be due yet
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (!rst && strobe) begin
      if (want_results.size() == 0 || want_results[0].born == cycle_no) begin
        flag_mismatch($sformatf("unexpected result: value %h count %0d status %0d last %0b",
                                result.read_value, result.element_count, result.status,
                                result.last));
      end else begin
        head_want = want_results.pop_front();
        if (result.read_value !== head_want.res.read_value ||
            result.element_count !== head_want.res.element_count ||
            result.status !== head_want.res.status ||
            result.last !== head_want.res.last)
          flag_mismatch($sformatf({"result mismatch: want value %h count %0d status %0d ",
                                   "last %0b, got value %h count %0d status %0d last %0b"},
                                  head_want.res.read_value, head_want.res.element_count,
                                  head_want.res.status, head_want.res.last,
                                  result.read_value, result.element_count, result.status,
                                  result.last));
      end
    end
  end

  initial begin
    int n;
    int phase;
    int roll;
    int act;
    int idle;
    bit growing;
    int phase_idle [4];

    phase_idle = '{0, 83, 0, 8};

    // directed: empty store, only-element delete, tail insert, range and unknown codes
    queue_request(ACT_DUMP,   0, '0, 1'b0, 0);
    queue_request(ACT_READ,   0, '0, 1'b0, 0);
    queue_request(ACT_DELETE, 0, '0, 1'b0, 0);
    queue_request(ACT_INSERT, 1, $urandom(), 1'b0, 0);
    queue_request(ACT_INSERT, 0, '0, 1'b0, 0);
    queue_request(ACT_DELETE, 0, '0, 1'b0, 0);
    queue_request(ACT_READ,   0, '0, 1'b0, 0);
    queue_request(ACT_INSERT, 0, '1, 1'b0, 0);
    queue_request(ACT_APPEND, 0, '0, 1'b0, 0);
    queue_request(ACT_INSERT, 2, $urandom(), 1'b0, 0);
    queue_request(ACT_INSERT, POS_MAX, $urandom(), 1'b0, 0);
    queue_request(ACT_READ,   POS_MAX, '0, 1'b0, 0);
    queue_request(ACT_READ,   2, '0, 1'b0, 0);
    queue_request(ACT_DELETE, 3, '0, 1'b0, 0);
    queue_request(ACT_DELETE, 1, '0, 1'b0, 0);
    for (act = ACT_DUMP + 1; act <= ACT_CODE_MAX; act++)
      queue_request(act[ACTION_BITS-1:0], POS_MAX, '1, 1'b0, 0);
    queue_request(ACT_DUMP,   0, '0, 1'b0, 0);

    // random: alternate filling and draining bursts so full and empty are both hit
    growing = 1'b1;
    n = 0;
    while (n < RANDOM_ITEMS) begin
      phase = n / PHASE_LEN;
      if (phase > 3) phase = 3;
      idle = phase_idle[phase];
      if (growing && gen_count == CAPACITY && $urandom_range(3) == 0) growing = 1'b0;
      if (!growing && gen_count == 0 && $urandom_range(3) == 0) growing = 1'b1;
      roll = $urandom_range(99);
      if (roll < 8) begin
        act = ACT_DUMP;
        queue_request(ACT_DUMP, $urandom_range(POS_MAX), pick_value(), n % PHASE_LEN == 0, idle);
      end else if (roll < 16) begin
        act = $urandom_range(ACT_CODE_MAX);
        queue_request(act[ACTION_BITS-1:0], $urandom_range(POS_MAX), $urandom(),
                      n % PHASE_LEN == 0, idle);
      end else if (roll < 30) begin
        act = ACT_READ;
        queue_request(ACT_READ, gen_count > 0 ? $urandom_range(gen_count - 1) : 0,
                      pick_value(), n % PHASE_LEN == 0, idle);
      end else if (growing) begin
        act = ACT_APPEND;
        if (roll < 60)
          queue_request(ACT_APPEND, $urandom_range(POS_MAX), pick_value(),
                        n % PHASE_LEN == 0, idle);
        else
          queue_request(ACT_INSERT, $urandom_range(gen_count), pick_value(),
                        n % PHASE_LEN == 0, idle);
      end else begin
        act = ACT_DELETE;
        queue_request(ACT_DELETE, gen_count > 0 ? $urandom_range(gen_count - 1) : 0,
                      pick_value(), n % PHASE_LEN == 0, idle);
      end
      if (act <= ACT_DUMP) n++;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || start || want_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    if (mismatches == 0 && want_results.size() == 0) begin
      $display("positional_list_store verification clean");
    end else begin
      $display("positional_list_store verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pls_pkg.sv
rtl/pls_cell.sv
rtl/positional_list_store.sv
rtl/pls_check.sv
tb/tb_positional_list_store.sv
